// File: rtl/edt_pkg.sv
// Package for the event dispatch table: sizes, opcodes and item types.
// Used by rtl/event_dispatch_table.sv; has no dependencies of its own.
package edt_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int EVENT_BITS   = 32;
    localparam int HANDLER_BITS = 8;
    localparam int CAP_W        = 5;
    localparam int OP_W         = 2;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_BIND_EXACT  = 2'd0,
        OP_BIND_FILTER = 2'd1,
        OP_DISPATCH    = 2'd2,
        OP_RESERVED    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [EVENT_BITS-1:0]   event_code;
        logic [HANDLER_BITS-1:0] handler_id;
        logic [EVENT_BITS-1:0]   set_pattern;
        logic [EVENT_BITS-1:0]   set_mask;
        logic [EVENT_BITS-1:0]   clear_pattern;
        logic [EVENT_BITS-1:0]   clear_mask;
    } in_item_t;

    typedef struct packed {
        logic                    status;
        logic [HANDLER_BITS-1:0] matched_handler;
        logic                    has_handler;
        logic                    last;
    } out_item_t;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [EVENT_BITS-1:0]   code_or_pattern;
        logic [EVENT_BITS-1:0]   set_mask;
        logic [EVENT_BITS-1:0]   clear_pattern;
        logic [HANDLER_BITS-1:0] handler;
    } entry_t;

endpackage

// File: rtl/event_dispatch_table.sv
// Event dispatch table: sorted exact-code region plus masked filters.
// Depends on rtl/edt_pkg.sv (sizes, opcodes, item and entry types).
//
// Usage:
//   s_valid/s_ready/s_item carry one command item (bind exact, bind filter,
//   dispatch). m_valid/m_ready/m_item return results; each bind gives one
//   result, a dispatch gives one exact hit, one result per accepting filter
//   (last set on the final one), or a single error result.
//   cfg_wr_en/cfg_wr_data write table_capacity; write only while idle.
// Sequence (one memory read port, registered read data): a bind filter, a
//   reserved opcode or a full table goes straight to the result state. Exact
//   binds and dispatches first binary-search the exact region, up to
//   log2(depth)+1 probes, each a read then a compare. A replaced code or an exact
//   dispatch hit then answers; a new exact code first moves every entry above it up
//   one by read then write; a miss scans all filters, matches coming out meanwhile.
//   One item at a time; s_ready is high only between items.
// Reset: counts clear, capacity returns to 16, entry memory is not cleared
//   (never read before written).
// Stall: a held result in the output register blocks the next result;
//   the scan pauses until the receiver takes it, nothing is dropped.
module event_dispatch_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  edt_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output edt_pkg::out_item_t  m_item,
    input  logic                cfg_wr_en,
    input  logic [edt_pkg::CAP_W-1:0] cfg_wr_data
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SRCH_RD  = 9'b000000010,
        ST_SRCH_CMP = 9'b000000100,
        ST_SHIFT_RD = 9'b000001000,
        ST_SHIFT_WR = 9'b000010000,
        ST_SCAN_RD  = 9'b000100000,
        ST_SCAN_CMP = 9'b001000000,
        ST_SCAN_END = 9'b010000000,
        ST_RESP     = 9'b100000000
    } state_t;

    localparam int CNT_W = edt_pkg::CNT_W;
    localparam int IDX_W = edt_pkg::IDX_W;

    // entry memory
    edt_pkg::entry_t mem [edt_pkg::TABLE_DEPTH];
    edt_pkg::entry_t rd_data_reg;
    logic            mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    edt_pkg::entry_t mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // control and working registers
    state_t state_reg, state_next;
    logic [edt_pkg::OP_W-1:0]         op_reg, op_next;
    logic [edt_pkg::EVENT_BITS-1:0]   ev_reg, ev_next;
    logic [edt_pkg::HANDLER_BITS-1:0] hd_reg, hd_next;
    logic [CNT_W-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] exact_cnt_reg, exact_cnt_next;
    logic [CNT_W-1:0] filter_cnt_reg, filter_cnt_next;
    logic [edt_pkg::CAP_W-1:0] cap_reg;
    logic pend_valid_reg, pend_valid_next;
    logic [edt_pkg::HANDLER_BITS-1:0] pend_hd_reg, pend_hd_next;
    edt_pkg::out_item_t resp_reg, resp_next;
    logic m_valid_reg, m_valid_next;
    edt_pkg::out_item_t m_item_reg, m_item_next;

    // derived values
    logic [CNT_W-1:0] fill;
    logic             full;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] idx_m1;
    logic             can_emit;
    logic             filter_hit;

    assign fill     = exact_cnt_reg + filter_cnt_reg;
    assign full     = 32'(fill) >= ((32'(cap_reg) > 32'(edt_pkg::TABLE_DEPTH)) ?
                      32'(edt_pkg::TABLE_DEPTH) : 32'(cap_reg));
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CNT_W:1];
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign can_emit = !m_valid_reg || m_ready;
    assign filter_hit =
        ((rd_data_reg.set_mask & ev_reg) == rd_data_reg.code_or_pattern) &&
        ((rd_data_reg.clear_pattern & ~ev_reg) == rd_data_reg.clear_pattern);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        ev_next         = ev_reg;
        hd_next         = hd_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        exact_cnt_next  = exact_cnt_reg;
        filter_cnt_next = filter_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_hd_next    = pend_hd_reg;
        resp_next       = resp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_item.opcode;
                    ev_next         = s_item.event_code;
                    hd_next         = s_item.handler_id;
                    lo_next         = '0;
                    hi_next         = exact_cnt_reg;
                    pend_valid_next = 1'b0;
                    resp_next       = '{status: 1'b1, matched_handler: '0,
                                        has_handler: 1'b0, last: 1'b1};
                    case (s_item.opcode)
                        edt_pkg::OP_BIND_EXACT: begin
                            state_next = full ? ST_RESP : ST_SRCH_RD;
                        end
                        edt_pkg::OP_BIND_FILTER: begin
                            if (!full) begin
                                mem_we    = 1'b1;
                                mem_waddr = fill[IDX_W-1:0];
                                mem_wdata = '{
                                    code_or_pattern: s_item.set_pattern & s_item.set_mask,
                                    set_mask:        s_item.set_mask,
                                    clear_pattern:   s_item.clear_pattern & s_item.clear_mask,
                                    handler:         s_item.handler_id};
                                filter_cnt_next  = filter_cnt_reg + CNT_W'(1);
                                resp_next.status = 1'b0;
                            end
                            state_next = ST_RESP;
                        end
                        edt_pkg::OP_DISPATCH: begin
                            state_next = ST_SRCH_RD;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // binary search over the exact region, each probe a read then a compare
            ST_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_SRCH_CMP;
                end else if (op_reg == edt_pkg::OP_BIND_EXACT) begin
                    idx_next   = fill;
                    state_next = ST_SHIFT_RD;
                end else begin
                    idx_next   = exact_cnt_reg;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SRCH_CMP: begin
                if (rd_data_reg.code_or_pattern < ev_reg) begin
                    lo_next    = mid_reg + CNT_W'(1);
                    state_next = ST_SRCH_RD;
                end else if (rd_data_reg.code_or_pattern > ev_reg) begin
                    hi_next    = mid_reg;
                    state_next = ST_SRCH_RD;
                end else if (op_reg == edt_pkg::OP_BIND_EXACT) begin
                    // code present: replace the handler only
                    mem_we            = 1'b1;
                    mem_waddr         = mid_reg[IDX_W-1:0];
                    mem_wdata         = rd_data_reg;
                    mem_wdata.handler = hd_reg;
                    resp_next.status  = 1'b0;
                    state_next        = ST_RESP;
                end else begin
                    resp_next  = '{status: 1'b0, matched_handler: rd_data_reg.handler,
                                   has_handler: 1'b1, last: 1'b1};
                    state_next = ST_RESP;
                end
            end

            // move entries up from the top down to the insert point
            ST_SHIFT_RD: begin
                if (idx_reg > lo_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_m1[IDX_W-1:0];
                    state_next = ST_SHIFT_WR;
                end else begin
                    mem_we           = 1'b1;
                    mem_waddr        = lo_reg[IDX_W-1:0];
                    mem_wdata        = '{code_or_pattern: ev_reg, set_mask: '0,
                                         clear_pattern: '0, handler: hd_reg};
                    exact_cnt_next   = exact_cnt_reg + CNT_W'(1);
                    resp_next.status = 1'b0;
                    state_next       = ST_RESP;
                end
            end

            ST_SHIFT_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_m1;
                state_next = ST_SHIFT_RD;
            end

            // filter scan; one match is held back so last can be marked
            ST_SCAN_RD: begin
                if (idx_reg < fill) begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[IDX_W-1:0];
                    state_next = ST_SCAN_CMP;
                end else begin
                    state_next = ST_SCAN_END;
                end
            end

            ST_SCAN_CMP: begin
                if (!filter_hit) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end else if (!pend_valid_reg || can_emit) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_item_next  = '{status: 1'b0, matched_handler: pend_hd_reg,
                                         has_handler: 1'b1, last: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_hd_next    = rd_data_reg.handler;
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = ST_SCAN_RD;
                end
            end

            ST_SCAN_END: begin
                if (can_emit) begin
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_item_next = '{status: 1'b0, matched_handler: pend_hd_reg,
                                        has_handler: 1'b1, last: 1'b1};
                    end else begin
                        m_item_next = '{status: 1'b1, matched_handler: '0,
                                        has_handler: 1'b0, last: 1'b1};
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RESP: begin
                if (can_emit) begin
                    m_valid_next = 1'b1;
                    m_item_next  = resp_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            exact_cnt_reg  <= '0;
            filter_cnt_reg <= '0;
            cap_reg        <= edt_pkg::CAP_RESET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            exact_cnt_reg  <= exact_cnt_next;
            filter_cnt_reg <= filter_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        ev_reg      <= ev_next;
        hd_reg      <= hd_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        pend_hd_reg <= pend_hd_next;
        resp_reg    <= resp_next;
        m_item_reg  <= m_item_next;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_dispatch_table: directed rows, then random items.
// Depends on rtl/edt_pkg.sv and rtl/event_dispatch_table.sv.
module tb_top;

    // one directed row: optional capacity write, the item, an optional fixed result
    typedef struct {
        bit                 set_cap;
        logic [4:0]         cap;
        edt_pkg::in_item_t  cmd;
        bit                 typed;
        edt_pkg::out_item_t want;
    } step_row_t;

    localparam edt_pkg::out_item_t BIND_OK    = '{status: 1'b0, matched_handler: 8'h00,
                                                  has_handler: 1'b0, last: 1'b1};
    localparam edt_pkg::out_item_t ERR_RESULT = '{status: 1'b1, matched_handler: 8'h00,
                                                  has_handler: 1'b0, last: 1'b1};

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    edt_pkg::in_item_t         s_item = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    edt_pkg::out_item_t        m_item;
    logic                      cfg_wr_en = 1'b0;
    logic [edt_pkg::CAP_W-1:0] cfg_wr_data = '0;

    // shadow copy of the table
    logic [edt_pkg::EVENT_BITS-1:0]   tbl_code  [edt_pkg::TABLE_DEPTH];
    logic [edt_pkg::EVENT_BITS-1:0]   tbl_smask [edt_pkg::TABLE_DEPTH];
    logic [edt_pkg::EVENT_BITS-1:0]   tbl_cpat  [edt_pkg::TABLE_DEPTH];
    logic [edt_pkg::HANDLER_BITS-1:0] tbl_hnd   [edt_pkg::TABLE_DEPTH];
    int n_exact = 0;
    int n_filter = 0;
    int cap_limit = 16;

    edt_pkg::out_item_t awaited_results[$];
    edt_pkg::out_item_t command_results[$];
    step_row_t directed_rows[$];

    bit calm = 1'b0;
    int mismatch_count = 0;
    int cmds_sent = 0;
    int results_checked = 0;
    int cap_writes = 0;

    event_dispatch_table u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 36);
    end

    // compare each accepted result with the oldest one awaited
    always @(posedge aclk) begin : result_check
        edt_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                $error("result arrived with no item awaiting it: %h", m_item);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_item.status);
                    mismatch_count++;
                end
                if (m_item.matched_handler !== want.matched_handler) begin
                    $error("matched_handler: expected %0d, got %0d",
                           want.matched_handler, m_item.matched_handler);
                    mismatch_count++;
                end
                if (m_item.has_handler !== want.has_handler) begin
                    $error("has_handler: expected %0d, got %0d",
                           want.has_handler, m_item.has_handler);
                    mismatch_count++;
                end
                if (m_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_item.last);
                    mismatch_count++;
                end
            end
        end
    end

    // apply one item to the shadow table, leaving its results in command_results
    function automatic void apply_command(edt_pkg::in_item_t it);
        int lim;
        int fill;
        int pos;
        bit found;
        edt_pkg::out_item_t r;
        command_results.delete();
        r = ERR_RESULT;
        lim = (cap_limit > edt_pkg::TABLE_DEPTH) ? edt_pkg::TABLE_DEPTH : cap_limit;
        fill = n_exact + n_filter;
        found = 1'b0;
        pos = 0;
        case (it.opcode)
            edt_pkg::OP_BIND_EXACT: begin
                if (fill < lim) begin
                    r.status = 1'b0;
                    for (int i = 0; i < n_exact; i++) begin
                        if (tbl_code[i] == it.event_code) begin
                            tbl_hnd[i] = it.handler_id;
                            found = 1'b1;
                        end else if (tbl_code[i] < it.event_code) begin
                            pos = i + 1;
                        end
                    end
                    // new code: everything above it, filters too, moves up one
                    if (!found) begin
                        for (int i = fill; i > pos; i--) begin
                            tbl_code[i]  = tbl_code[i-1];
                            tbl_smask[i] = tbl_smask[i-1];
                            tbl_cpat[i]  = tbl_cpat[i-1];
                            tbl_hnd[i]   = tbl_hnd[i-1];
                        end
                        tbl_code[pos]  = it.event_code;
                        tbl_smask[pos] = '0;
                        tbl_cpat[pos]  = '0;
                        tbl_hnd[pos]   = it.handler_id;
                        n_exact++;
                    end
                end
                command_results.push_back(r);
            end
            edt_pkg::OP_BIND_FILTER: begin
                if (fill < lim) begin
                    r.status = 1'b0;
                    tbl_code[fill]  = it.set_pattern & it.set_mask;
                    tbl_smask[fill] = it.set_mask;
                    tbl_cpat[fill]  = it.clear_pattern & it.clear_mask;
                    tbl_hnd[fill]   = it.handler_id;
                    n_filter++;
                end
                command_results.push_back(r);
            end
            edt_pkg::OP_DISPATCH: begin
                for (int i = 0; i < n_exact; i++) begin
                    if (tbl_code[i] == it.event_code) begin
                        found = 1'b1;
                        r = '{status: 1'b0, matched_handler: tbl_hnd[i],
                              has_handler: 1'b1, last: 1'b1};
                    end
                end
                if (found) begin
                    command_results.push_back(r);
                end else begin
                    // no exact hit: every accepting filter, in table order
                    for (int i = n_exact; i < fill; i++) begin
                        if ((tbl_smask[i] & it.event_code) == tbl_code[i] &&
                            (tbl_cpat[i] & ~it.event_code) == tbl_cpat[i]) begin
                            command_results.push_back('{status: 1'b0,
                                matched_handler: tbl_hnd[i], has_handler: 1'b1, last: 1'b0});
                        end
                    end
                    if (command_results.size() == 0) begin
                        command_results.push_back(ERR_RESULT);
                    end else begin
                        r = command_results.pop_back();
                        r.last = 1'b1;
                        command_results.push_back(r);
                    end
                end
            end
            default: begin
                command_results.push_back(ERR_RESULT);
            end
        endcase
    endfunction

    function automatic edt_pkg::in_item_t mk_cmd(edt_pkg::opcode_t op, logic [31:0] ev,
                                                 logic [7:0] hd,
                                                 logic [31:0] sp, logic [31:0] sm,
                                                 logic [31:0] cp, logic [31:0] cm);
        edt_pkg::in_item_t it;
        it.opcode        = op;
        it.event_code    = ev;
        it.handler_id    = hd;
        it.set_pattern   = sp;
        it.set_mask      = sm;
        it.clear_pattern = cp;
        it.clear_mask    = cm;
        return it;
    endfunction

    function automatic step_row_t mk_row(bit set_cap, logic [4:0] cap,
                                         edt_pkg::in_item_t cmd,
                                         bit typed, edt_pkg::out_item_t want);
        step_row_t rw;
        rw.set_cap = set_cap;
        rw.cap     = cap;
        rw.cmd     = cmd;
        rw.typed   = typed;
        rw.want    = want;
        return rw;
    endfunction

    function automatic edt_pkg::out_item_t exact_hit(logic [7:0] hd);
        return '{status: 1'b0, matched_handler: hd, has_handler: 1'b1, last: 1'b1};
    endfunction

    // random item, biased toward codes and filters the table already holds
    function automatic edt_pkg::in_item_t random_command();
        edt_pkg::in_item_t it;
        int pick;
        int k;
        int idx;
        logic [31:0] ev;
        it = mk_cmd(edt_pkg::OP_DISPATCH, $urandom, 8'($urandom), $urandom, $urandom,
                    $urandom, $urandom);
        pick = $urandom_range(99);
        k = $urandom_range(2);
        if (pick < 45) begin
            if (k == 0 && n_exact > 0) begin
                it.event_code = tbl_code[$urandom_range(n_exact - 1)];
            end else if (k == 1 && n_filter > 0) begin
                // build an event that this filter should accept
                idx = n_exact + $urandom_range(n_filter - 1);
                ev = ($urandom & ~tbl_smask[idx]) | tbl_code[idx];
                it.event_code = ev & ~tbl_cpat[idx];
            end
        end else if (pick < 70) begin
            it.opcode = edt_pkg::OP_BIND_EXACT;
            if (k == 0 && n_exact > 0) begin
                it.event_code = tbl_code[$urandom_range(n_exact - 1)];
            end else if (k == 1) begin
                it.event_code = $urandom_range(63);
            end
        end else if (pick < 92) begin
            it.opcode = edt_pkg::OP_BIND_FILTER;
            if (k == 0) begin
                it.set_mask   = $urandom & $urandom & $urandom;
                it.clear_mask = $urandom & $urandom & $urandom;
            end else if (k == 1 && $urandom_range(2) == 0) begin
                // accepts every event
                it.set_mask   = '0;
                it.clear_mask = '0;
            end
        end else begin
            it.opcode = edt_pkg::OP_RESERVED;
        end
        return it;
    endfunction

    // send one item, then record what it should produce
    task automatic issue(edt_pkg::in_item_t it, bit typed, edt_pkg::out_item_t want);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 36 && gap < 12) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(it);
        if (typed) begin
            awaited_results.push_back(want);
        end else begin
            foreach (command_results[i]) awaited_results.push_back(command_results[i]);
        end
        cmds_sent++;
    endtask

    // drain, let the block go idle, then optionally write the capacity
    task automatic settle(bit do_write, logic [4:0] cap);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (do_write) begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= cap;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            cap_limit = cap;
            cap_writes++;
        end
    endtask

    // run length guard
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [4:0] phase_cap [5];
        int         phase_len [5];
        phase_cap = '{5'd10, 5'd1, 5'd14, 5'd16, 5'd31};
        phase_len = '{85, 35, 95, 85, 85};

        // directed rows
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 0), 1, ERR_RESULT));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_RESERVED, 0, 0, 0, 0, 0, 0), 1, ERR_RESULT));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'hFFFF_FFFF, 8'hFF, 0, 0, 0, 0), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h0, 8'h00, 0, 0, 0, 0), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h8000_0000, 8'h5A, 0, 0, 0, 0), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'hFFFF_FFFF, 0, 0, 0, 0, 0),
            1, exact_hit(8'hFF)));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0, 0, 0, 0, 0, 0), 1, exact_hit(8'h00)));
        // same code again only replaces the handler
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h0, 8'hA5, 0, 0, 0, 0), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0, 0, 0, 0, 0, 0), 1, exact_hit(8'hA5)));
        // filters: accept-all, low-byte match, near all-ones match
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_FILTER, 0, 8'h11, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0),
            1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_FILTER, 0, 8'h22, 32'h0000_00F0, 32'h0000_00FF,
                   32'hFFFF_0000, 32'h0F00_0000), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_FILTER, 0, 8'h33, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                   0, 32'hFFFF_FFFF), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0000_00F0, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0F00_00F0, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'hFFFF_FFFE, 0, 0, 0, 0, 0), 0, '0));
        // insert below the filters, which move up
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h0000_1234, 8'h44, 0, 0, 0, 0), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0000_1234, 0, 0, 0, 0, 0),
            1, exact_hit(8'h44)));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0000_00F0, 0, 0, 0, 0, 0), 0, '0));
        // zero capacity: even a replacement fails, dispatch still works
        directed_rows.push_back(mk_row(1, 5'd0,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h0000_1234, 8'h77, 0, 0, 0, 0),
            1, ERR_RESULT));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_BIND_FILTER, 0, 8'h01, 0, 0, 0, 0), 1, ERR_RESULT));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h0000_1234, 0, 0, 0, 0, 0),
            1, exact_hit(8'h44)));
        // capacity equal to fill, then above the depth
        directed_rows.push_back(mk_row(1, 5'd7,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h5, 8'h05, 0, 0, 0, 0), 1, ERR_RESULT));
        directed_rows.push_back(mk_row(1, 5'd31,
            mk_cmd(edt_pkg::OP_BIND_EXACT, 32'h5, 8'h05, 0, 0, 0, 0), 1, BIND_OK));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_DISPATCH, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.push_back(mk_row(0, 0,
            mk_cmd(edt_pkg::OP_RESERVED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, ERR_RESULT));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_cap) settle(1'b1, directed_rows[i].cap);
            issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, one capacity each; the capacity-16 phase runs without idling
        for (int p = 0; p < 5; p++) begin
            settle(1'b1, phase_cap[p]);
            calm = (phase_cap[p] == 5'd16);
            repeat (phase_len[p]) issue(random_command(), 1'b0, '0);
        end

        settle(1'b0, 5'd0);
        repeat (40) @(posedge aclk);
        $display("tb: %0d items sent, %0d results checked, %0d capacity writes",
                 cmds_sent, results_checked, cap_writes);
        $display("tb: table finished holding %0d exact codes and %0d filters",
                 n_exact, n_filter);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
